@@ rtl/sat_pkg.sv @@
// Shared types and codes for the section table address translator.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package sat_pkg;

  // Operation codes of an input word
  localparam logic [1:0] OP_LOAD     = 2'd0;
  localparam logic [1:0] OP_VIRT2RAW = 2'd1;
  localparam logic [1:0] OP_RAW2VIRT = 2'd2;
  localparam logic [1:0] OP_RAWSECT  = 2'd3;

  // Register map: index is paddr[3], registers are 8 bytes apart
  localparam int          PADDR_W           = 4;
  localparam int          PDATA_W           = 64;
  localparam logic        REG_IMAGE_BASE    = 1'b0;
  localparam logic        REG_SECTION_COUNT = 1'b1;

  // Width of index and count arithmetic, wide enough for 256 entries
  localparam int          CNT_W = 9;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  entry_index;
    logic [63:0] entry_virt_addr;
    logic [31:0] entry_virt_size;
    logic [31:0] entry_raw_offset;
    logic [31:0] entry_raw_size;
    logic [63:0] query_addr;
  } sat_in_t;

  typedef struct packed {
    logic [63:0] result_addr;
    logic        found;
    logic [3:0]  match_index;
  } sat_out_t;

  // One table entry as stored: the virtual end carry and the 32-bit file end
  // are computed once at load time.
  typedef struct packed {
    logic [63:0] virt_addr;
    logic [31:0] virt_size;
    logic        virt_wrap;
    logic [31:0] raw_offset;
    logic [31:0] raw_end;
  } sat_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic start;
    logic rd_en;
    logic eval_en;
    logic out_load;
  } sat_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_load;
    logic no_entries;
    logic at_last;
    logic out_free;
  } sat_stat_t;

endpackage

@@ rtl/sat_regs.sv @@
// Configuration registers (image base, section count) behind the APB port.
// Depends on sat_pkg.
`timescale 1ns / 1ps

module sat_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sat_pkg::PADDR_W-1:0] paddr,
  input  logic [sat_pkg::PDATA_W-1:0] pwdata,
  output logic [sat_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic [63:0]                 image_base_o,
  output logic [4:0]                  section_count_o
);
  import sat_pkg::*;

  logic [63:0] image_base_q;
  logic [4:0]  section_count_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_base_q    <= '0;
      section_count_q <= 5'd1;
    end else if (wr_en) begin
      unique case (paddr[3])
        REG_IMAGE_BASE:    image_base_q    <= pwdata;
        REG_SECTION_COUNT: section_count_q <= pwdata[4:0];
        default:           image_base_q    <= image_base_q;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[3])
      REG_IMAGE_BASE:    prdata = image_base_q;
      REG_SECTION_COUNT: prdata = {59'd0, section_count_q};
      default:           prdata = '0;
    endcase
  end

  assign image_base_o    = image_base_q;
  assign section_count_o = section_count_q;

endmodule

@@ rtl/sat_dp.sv @@
// Datapath: section table memory, per-entry match unit, best-match registers
// and the output word register. Depends on sat_pkg; driven by sat_ctrl.
`timescale 1ns / 1ps

module sat_dp #(
  parameter int MAX_SECTIONS = 16,
  parameter int IDX_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sat_pkg::sat_in_t   in_data_i,
  output sat_pkg::sat_out_t  out_data_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic [63:0]        image_base_i,
  input  logic [4:0]         section_count_i,
  input  sat_pkg::sat_cmd_t  cmd_i,
  input  logic [IDX_W-1:0]   rd_addr_i,
  output sat_pkg::sat_stat_t stat_o
);
  import sat_pkg::*;

  localparam logic [CNT_W-1:0] MaxN = CNT_W'(MAX_SECTIONS);

  // Table memory
  sat_entry_t mem [MAX_SECTIONS];
  sat_entry_t rd_q;
  logic [IDX_W-1:0] ev_idx_q;

  // Item registers
  logic [1:0]  op_q;
  logic [63:0] qa_q;

  // Best match so far
  logic              found_q;
  logic [31:0]       off_q;
  logic [63:0]       base_q;
  logic [IDX_W-1:0]  idx_q;

  // Output word register
  logic     out_vld_q;
  sat_out_t out_q;

  logic [CNT_W-1:0] n_act;
  logic [CNT_W-1:0] sc_ext;
  logic [CNT_W-1:0] slot_ext;
  logic             slot_ok;
  logic             is_load;
  sat_entry_t       wr_entry;
  logic [64:0]      virt_end;

  logic [64:0] v_diff;
  logic        v_match;
  logic [32:0] f_diff;
  logic        f_match;
  logic        hit;
  logic [31:0] hit_off;
  logic        better;
  logic [63:0] res_addr;

  // Active entry count, capped at the table depth
  assign sc_ext   = CNT_W'(section_count_i);
  assign n_act    = (sc_ext > MaxN) ? MaxN : sc_ext;
  assign slot_ext = CNT_W'(in_data_i.entry_index);
  assign slot_ok  = slot_ext < MaxN;
  assign is_load  = in_data_i.operation == OP_LOAD;

  assign stat_o.is_load    = is_load;
  assign stat_o.no_entries = n_act == '0;
  assign stat_o.at_last    = CNT_W'(rd_addr_i) == (n_act - CNT_W'(1));
  assign stat_o.out_free   = !out_vld_q || !out_stall_i;

  // Precompute the end carry and the wrapped file end for the stored entry
  assign virt_end = {1'b0, in_data_i.entry_virt_addr} + {33'd0, in_data_i.entry_virt_size};
  always_comb begin
    wr_entry.virt_addr  = in_data_i.entry_virt_addr;
    wr_entry.virt_size  = in_data_i.entry_virt_size;
    wr_entry.virt_wrap  = virt_end[64];
    wr_entry.raw_offset = in_data_i.entry_raw_offset;
    wr_entry.raw_end    = in_data_i.entry_raw_offset + in_data_i.entry_raw_size;
  end

  // Memory write on a load, registered read during the scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.start && is_load && slot_ok) begin
      mem[slot_ext[IDX_W-1:0]] <= wr_entry;
    end
    if (cmd_i.rd_en) begin
      rd_q     <= mem[rd_addr_i];
      ev_idx_q <= rd_addr_i;
    end
  end

  // Virtual match: offset below size, no end wrap, zero start skipped
  // when more than one entry is in use
  assign v_diff  = {1'b0, qa_q} - {1'b0, rd_q.virt_addr};
  assign v_match = !v_diff[64] && (v_diff[63:32] == 32'd0)
                   && (v_diff[31:0] < rd_q.virt_size) && !rd_q.virt_wrap
                   && !((n_act > CNT_W'(1)) && (rd_q.virt_addr == 64'd0));

  // File match: offset in [raw_offset, wrapped end)
  assign f_diff  = {1'b0, qa_q[31:0]} - {1'b0, rd_q.raw_offset};
  assign f_match = (qa_q[63:32] == 32'd0) && !f_diff[32]
                   && (qa_q[31:0] < rd_q.raw_end);

  assign hit     = (op_q == OP_VIRT2RAW) ? v_match : f_match;
  assign hit_off = (op_q == OP_VIRT2RAW) ? v_diff[31:0] : f_diff[31:0];
  assign better  = !found_q || (hit_off < off_q);

  // Capture the item, then keep the smallest offset; first one wins a tie
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.start) begin
      found_q <= is_load && slot_ok;
    end else if (cmd_i.eval_en && hit && better) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q   <= in_data_i.operation;
      qa_q   <= (in_data_i.operation == OP_VIRT2RAW)
                ? in_data_i.query_addr - image_base_i : in_data_i.query_addr;
      off_q  <= '0;
      base_q <= '0;
      idx_q  <= '0;
    end else if (cmd_i.eval_en && hit && better) begin
      off_q  <= hit_off;
      idx_q  <= ev_idx_q;
      base_q <= (op_q == OP_VIRT2RAW) ? {32'd0, rd_q.raw_offset} : rd_q.virt_addr;
    end
  end

  // Final translation add
  assign res_addr = (found_q && (op_q == OP_VIRT2RAW || op_q == OP_RAW2VIRT))
                    ? base_q + {32'd0, off_q} : 64'd0;

  // Output word: hold while stalled, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.result_addr <= res_addr;
      out_q.found       <= found_q;
      out_q.match_index <= 4'(idx_q);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/sat_ctrl.sv @@
// Controller: accepts words, sequences the table scan one entry per cycle
// and hands the result to the output register. Depends on sat_pkg.
`timescale 1ns / 1ps

module sat_ctrl #(
  parameter int MAX_SECTIONS = 16,
  parameter int IDX_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sat_pkg::sat_stat_t stat_i,
  output sat_pkg::sat_cmd_t  cmd_o,
  output logic [IDX_W-1:0]   rd_addr_o
);
  import sat_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LAST = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             eval_q;

  assign in_stall_o = state_q != S_IDLE;
  assign rd_addr_o  = cnt_q;

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    cmd_o.start    = 1'b0;
    cmd_o.rd_en    = 1'b0;
    cmd_o.eval_en  = eval_q;
    cmd_o.out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          cnt_d       = '0;
          if (stat_i.is_load || stat_i.no_entries) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (stat_i.at_last) begin
          state_d = S_LAST;
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
        end
      end
      S_LAST: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      eval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      eval_q  <= cmd_o.rd_en;
    end
  end

`ifndef SYNTH
  // Each evaluation follows a read issued in the previous cycle
  a_eval_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.eval_en |-> $past(cmd_o.rd_en))
    else $error("entry evaluated without a prior read");

  // The scan stops at the last active entry
  a_scan_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.rd_en && stat_i.at_last) |=> (state_q == S_LAST && !cmd_o.rd_en))
    else $error("scan ran past the last entry");

  // Loads and empty tables skip the scan
  a_no_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.start && (stat_i.is_load || stat_i.no_entries)) |=> state_q == S_DONE)
    else $error("scan started for a load or an empty table");

  // A result is only loaded when the output register can take it
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (stat_i.out_free && !cmd_o.eval_en))
    else $error("result loaded over a pending word");
`endif

endmodule

@@ rtl/section_table_address_translator.sv @@
// Top level of the section table address translator: APB registers,
// controller and datapath. Depends on sat_pkg, sat_regs, sat_ctrl, sat_dp.
`timescale 1ns / 1ps

//  channel   | handshake                    | payload
//  ----------+------------------------------+----------------------------
//  input     | in_valid_i / in_stall_o      | in_data_i  (sat_in_t)
//  output    | out_valid_o / out_stall_i    | out_data_o (sat_out_t)
//  config    | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// A load word is accepted and written to the table, then its result is handed off.
// A query does one table read per active entry, n = min(section_count,
// MAX_SECTIONS); with n = 0 the scan is skipped.
// Reset clears control and the image base and sets the section count to 1; table contents are not cleared.
// A stalled output word holds; a new word is accepted once the previous
// result has moved into the output register.

module section_table_address_translator #(
  parameter int MAX_SECTIONS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  sat_pkg::sat_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output sat_pkg::sat_out_t           out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sat_pkg::PADDR_W-1:0] paddr,
  input  logic [sat_pkg::PDATA_W-1:0] pwdata,
  output logic [sat_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import sat_pkg::*;

  localparam int IdxW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  logic [63:0]     image_base;
  logic [4:0]      section_count;
  sat_cmd_t        cmd;
  sat_stat_t       stat;
  logic [IdxW-1:0] rd_addr;

  sat_regs u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .image_base_o    (image_base),
    .section_count_o (section_count)
  );

  sat_ctrl #(
    .MAX_SECTIONS (MAX_SECTIONS),
    .IDX_W        (IdxW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr)
  );

  sat_dp #(
    .MAX_SECTIONS (MAX_SECTIONS),
    .IDX_W        (IdxW)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_data_i       (in_data_i),
    .out_data_o      (out_data_o),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .image_base_i    (image_base),
    .section_count_i (section_count),
    .cmd_i           (cmd),
    .rd_addr_i       (rd_addr),
    .stat_o          (stat)
  );

endmodule

@@ verif/section_table_address_translator_tb.sv @@
// Self-checking testbench for section_table_address_translator: loads section tables,
// sweeps the APB registers and checks every translation result against an in-bench model.
// Depends on sat_pkg and the RTL of the translator; needs no files or arguments.
`timescale 1ns / 1ps

module section_table_address_translator_tb;
  import sat_pkg::*;

  localparam int NUM_SECTIONS = 16;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 30;
  localparam int REPORT_MAX   = 10;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  sat_in_t             in_data     = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  sat_out_t            out_data;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [PADDR_W-1:0]  paddr       = '0;
  logic [PDATA_W-1:0]  pwdata      = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // Model of the section table and the registers
  logic [63:0] tbl_virt_base [NUM_SECTIONS];
  logic [31:0] tbl_virt_len  [NUM_SECTIONS];
  logic [31:0] tbl_file_base [NUM_SECTIONS];
  logic [31:0] tbl_file_len  [NUM_SECTIONS];
  logic [63:0] cur_image_base = '0;
  logic [4:0]  cur_count      = 5'd1;

  sat_out_t    pending_translations [$];
  int          errors      = 0;
  int          idle_cycles = 0;
  int          stall_left  = 0;
  bit          send_gaps   = 1'b1;
  bit          sink_stalls = 1'b1;
  logic [63:0] va_region   = 64'h0000_0000_0040_0000;
  logic [31:0] raw_region  = 32'h0000_1000;

  section_table_address_translator #(
    .MAX_SECTIONS(NUM_SECTIONS)
  ) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #2 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int active_count();
    return (int'(cur_count) > NUM_SECTIONS) ? NUM_SECTIONS : int'(cur_count);
  endfunction

  // Compute the result of one word and apply its effect on the table
  function automatic sat_out_t translate_word(input sat_in_t w);
    sat_out_t    r;
    int          n;
    int          win;
    int          i;
    logic [63:0] va;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] best;
    logic [31:0] file_end;
    r    = '0;
    n    = active_count();
    win  = -1;
    best = '1;
    case (w.operation)
      OP_LOAD: begin
        tbl_virt_base[w.entry_index] = w.entry_virt_addr;
        tbl_virt_len[w.entry_index]  = w.entry_virt_size;
        tbl_file_base[w.entry_index] = w.entry_raw_offset;
        tbl_file_len[w.entry_index]  = w.entry_raw_size;
        r.found = 1'b1;
      end
      OP_VIRT2RAW: begin
        va = w.query_addr - cur_image_base;
        for (i = 0; i < n; i++) begin
          lo = tbl_virt_base[i];
          hi = lo + {32'd0, tbl_virt_len[i]};
          // zero-based sections are ignored once the table has several entries
          if (n > 1 && lo == 64'd0) continue;
          if (va >= lo && va < hi && (va - lo) < best) begin
            best = va - lo;
            win  = i;
          end
        end
        if (win >= 0) begin
          r.result_addr = {32'd0, tbl_file_base[win]} + (va - tbl_virt_base[win]);
          r.found       = 1'b1;
          r.match_index = 4'(win);
        end
      end
      default: begin
        for (i = 0; i < n; i++) begin
          lo       = {32'd0, tbl_file_base[i]};
          file_end = tbl_file_base[i] + tbl_file_len[i];
          hi       = {32'd0, file_end};
          if (w.query_addr >= lo && w.query_addr < hi && (w.query_addr - lo) < best) begin
            best = w.query_addr - lo;
            win  = i;
          end
        end
        if (win >= 0) begin
          if (w.operation == OP_RAW2VIRT)
            r.result_addr = tbl_virt_base[win] +
                            (w.query_addr - {32'd0, tbl_file_base[win]});
          r.found       = 1'b1;
          r.match_index = 4'(win);
        end
      end
    endcase
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    errors++;
    if (errors <= REPORT_MAX)
      $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, exp_v, act_v);
  endtask

  // Send one word, with an optional gap before it; record its expected result
  task automatic push_word(input sat_in_t w);
    int gap;
    @(negedge clk);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = w;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_translations.push_back(translate_word(w));
  endtask

  task automatic load_word(input int slot, input logic [63:0] va, input logic [31:0] vlen,
                           input logic [31:0] foff, input logic [31:0] flen);
    sat_in_t w;
    w                  = '0;
    w.operation        = OP_LOAD;
    w.entry_index      = 4'(slot);
    w.entry_virt_addr  = va;
    w.entry_virt_size  = vlen;
    w.entry_raw_offset = foff;
    w.entry_raw_size   = flen;
    w.query_addr       = rand64();
    push_word(w);
  endtask

  task automatic query_word(input logic [1:0] op, input logic [63:0] q);
    sat_in_t w;
    w                  = '0;
    w.operation        = op;
    w.entry_index      = 4'($urandom);
    w.entry_virt_addr  = rand64();
    w.entry_virt_size  = $urandom;
    w.entry_raw_offset = $urandom;
    w.entry_raw_size   = $urandom;
    w.query_addr       = q;
    push_word(w);
  endtask

  // Drop valid, wait for every result, then let the design idle
  task automatic settle_block();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_translations.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write followed by a read back of the same register
  task automatic cfg_write(input logic idx, input logic [63:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 3'b000};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_IMAGE_BASE) cur_image_base = value;
    else                       cur_count      = value[4:0];
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_IMAGE_BASE) begin
      if (prdata !== cur_image_base) note_mismatch("image_base read", cur_image_base, prdata);
    end else begin
      if (prdata[4:0] !== cur_count)
        note_mismatch("section_count read", 64'(cur_count), 64'(prdata[4:0]));
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_registers(input logic [63:0] base, input logic [4:0] count);
    settle_block();
    cfg_write(REG_IMAGE_BASE, base);
    cfg_write(REG_SECTION_COUNT, {59'(rand64()), count});
  endtask

  // Random section, mostly inside the current clusters so that entries overlap
  task automatic random_load(input int slot);
    int          style;
    logic [63:0] va;
    logic [31:0] vlen;
    logic [31:0] foff;
    logic [31:0] flen;
    style = $urandom_range(0, 9);
    va    = va_region + 64'($urandom_range(0, 'h7000));
    vlen  = $urandom_range(0, 'h3000);
    foff  = raw_region + $urandom_range(0, 'h7000);
    flen  = $urandom_range(0, 'h3000);
    case (style)
      7: begin
        va   = rand64();
        vlen = $urandom;
        foff = $urandom;
        flen = $urandom;
      end
      8: begin
        // zero base, or a virtual range that wraps past the top
        if ($urandom_range(0, 1) == 0) va = 64'd0;
        else va = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 'h1000));
      end
      9: begin
        // file range that wraps past 4 GiB
        foff = 32'hFFFF_FFFF - $urandom_range(0, 'h2000);
        flen = $urandom_range(0, 'h4000);
      end
      default: ;
    endcase
    load_word(slot, va, vlen, foff, flen);
  endtask

  // Query that mostly lands in, at the edge of, or just past a live section
  task automatic random_query();
    logic [1:0]  op;
    int          n;
    int          idx;
    int          pick;
    logic [31:0] len;
    logic [63:0] off;
    logic [63:0] q;
    op = 2'($urandom_range(1, 3));
    n  = active_count();
    if ($urandom_range(0, 9) < 7) begin
      idx  = $urandom_range(0, (n > 0) ? n - 1 : NUM_SECTIONS - 1);
      len  = (op == OP_VIRT2RAW) ? tbl_virt_len[idx] : tbl_file_len[idx];
      pick = $urandom_range(0, 7);
      if (pick == 0)      off = 64'd0;
      else if (pick == 1) off = {32'd0, len};
      else if (pick == 2) off = (len == 0) ? 64'd0 : {32'd0, len - 32'd1};
      else                off = {32'd0, 32'($urandom_range(0, len))};
      if (op == OP_VIRT2RAW) q = tbl_virt_base[idx] + off + cur_image_base;
      else                   q = {32'd0, tbl_file_base[idx]} + off;
    end else if ($urandom_range(0, 1) == 0) begin
      q = rand64();
    end else if (op == OP_VIRT2RAW) begin
      q = va_region + 64'($urandom_range(0, 'hA000)) + cur_image_base;
    end else begin
      q = {32'd0, raw_region} + 64'($urandom_range(0, 'hA000));
    end
    query_word(op, q);
  endtask

  // Fill every slot, then query with the reset register values: one entry, no base
  task automatic test_table_fill();
    int s;
    load_word(0, 64'h0, 32'h1000, 32'h0, 32'h400);
    load_word(1, 64'h1000, 32'h2000, 32'h400, 32'h1000);
    load_word(2, 64'h1800, 32'h1000, 32'h800, 32'h800);
    load_word(3, 64'h1000, 32'h2000, 32'h400, 32'h1000);
    load_word(4, 64'hFFFF_FFFF_FFFF_F000, 32'h2000, 32'hFFFF_F000, 32'h2000);
    load_word(5, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    load_word(6, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0);
    for (s = 7; s < NUM_SECTIONS; s++) random_load(s);
    query_word(OP_VIRT2RAW, 64'h0);
    query_word(OP_RAW2VIRT, 64'h3FF);
    query_word(OP_RAWSECT, 64'h400);
  endtask

  // Overlaps, ties, wrapping ranges and the field extremes on the full table
  task automatic test_overlap_and_wrap();
    set_registers(64'h0, 5'd16);
    query_word(OP_VIRT2RAW, 64'h0);
    query_word(OP_VIRT2RAW, 64'h1800);
    query_word(OP_VIRT2RAW, 64'h1000);
    query_word(OP_VIRT2RAW, 64'hFFFF_FFFF_FFFF_F800);
    query_word(OP_VIRT2RAW, 64'hFFFF_FFFF_FFFF_FFFF);
    query_word(OP_RAW2VIRT, 64'hFFFF_F800);
    query_word(OP_RAW2VIRT, 64'h1_0000_0000);
    query_word(OP_RAWSECT, 64'hFFFF_FFFF);
    query_word(OP_RAWSECT, 64'h900);
    set_registers(64'hFFFF_FFFF_FFFF_FFFF, 5'd16);
    query_word(OP_VIRT2RAW, 64'h0FFF);
    query_word(OP_VIRT2RAW, 64'h8000_0000_0000_0100);
  endtask

  // Empty table search and a count beyond the table
  task automatic test_count_limits();
    int k;
    set_registers(rand64(), 5'd0);
    for (k = 0; k < 6; k++) random_query();
    set_registers(64'h0, 5'd31);
    for (k = 0; k < 6; k++) random_query();
    set_registers(64'h0, 5'd17);
    for (k = 0; k < 4; k++) random_query();
  endtask

  task automatic test_random_traffic(input int phases, input int items);
    int          p;
    int          k;
    int          n;
    logic [63:0] base;
    logic [4:0]  count;
    for (p = 0; p < phases; p++) begin
      case (p % 6)
        0:       count = 5'd16;
        1:       count = 5'd1;
        2:       count = 5'($urandom_range(2, 15));
        3:       count = 5'($urandom_range(17, 31));
        4:       count = 5'($urandom_range(1, 16));
        default: count = 5'd0;
      endcase
      case ($urandom_range(0, 3))
        0:       base = 64'h0;
        1:       base = 64'hFFFF_FFFF_FFFF_FFFF;
        2:       base = rand64();
        default: base = rand64() & ~64'hF_FFFF;
      endcase
      set_registers(base, count);
      va_region   = ($urandom_range(0, 3) == 0) ? 64'h0 : (rand64() & ~64'hF_FFFF);
      raw_region  = ($urandom_range(0, 3) == 0) ? 32'hFFFF_0000 : ($urandom & ~32'hFFFF);
      send_gaps   = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);
      n = active_count();
      // build a fresh layout, then query it
      for (k = 0; k < $urandom_range(4, 10); k++)
        random_load($urandom_range(0, (n > 0) ? n - 1 : NUM_SECTIONS - 1));
      for (k = 0; k < items; k++) begin
        if ($urandom_range(0, 99) < 12) random_load($urandom_range(0, NUM_SECTIONS - 1));
        else                            random_query();
      end
    end
  endtask

  // Back-to-back traffic on the full table with both sides always ready
  task automatic test_steady_stream(input int items);
    int k;
    set_registers(rand64(), 5'd16);
    send_gaps   = 1'b0;
    sink_stalls = 1'b0;
    for (k = 0; k < items; k++) begin
      if ($urandom_range(0, 9) == 0) random_load($urandom_range(0, NUM_SECTIONS - 1));
      else                           random_query();
    end
  endtask

  // Receiver stalls in random bursts
  always @(negedge clk) begin
    if (stall_left > 0)
      stall_left--;
    else if (sink_stalls && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 9);
    out_stall = (stall_left > 0);
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    sat_out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_translations.size() == 0) begin
        note_mismatch("unexpected result", 64'h0, out_data.result_addr);
      end else begin
        exp_r = pending_translations.pop_front();
        if (out_data.result_addr !== exp_r.result_addr)
          note_mismatch("result_addr", exp_r.result_addr, out_data.result_addr);
        if (out_data.found !== exp_r.found)
          note_mismatch("found", 64'(exp_r.found), 64'(out_data.found));
        if (out_data.match_index !== exp_r.match_index)
          note_mismatch("match_index", 64'(exp_r.match_index), 64'(out_data.match_index));
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("section_table_address_translator test failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    test_table_fill();
    test_overlap_and_wrap();
    test_count_limits();
    test_random_traffic(8, 110);
    test_steady_stream(150);
    settle_block();
    if (errors == 0) begin
      $display("section_table_address_translator test passed");
    end else begin
      $display("section_table_address_translator test failed");
    end
    $finish;
  end

endmodule
